// ===== design/windowed_flow_imbalance_guard_unit_defines.svh =====
// Assertion macros used by the guard unit's datapath; they sample on clk, disabled in reset.
`ifndef WINDOWED_FLOW_IMBALANCE_GUARD_UNIT_DEFINES_SVH
`define WINDOWED_FLOW_IMBALANCE_GUARD_UNIT_DEFINES_SVH

// Condition must hold whenever the antecedent holds in the same cycle.
`define WFIG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wfig check failed");

// Condition must hold in the cycle after the antecedent.
`define WFIG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wfig check failed");

`endif

// ===== design/wfig_pkg.sv =====
// Shared types, widths and codes of the windowed flow imbalance guard.
`default_nettype none
package wfig_pkg;

  localparam int TIME_W     = 48;
  localparam int QTY_W      = 16;
  localparam int VOL_W      = 21;
  localparam int RATIO_W    = 29;
  localparam int WIN_W      = 16;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 29;
  localparam int MS_PER_S   = 1000;
  localparam int MS_W       = 10;

  localparam int DEF_KEYS    = 16;
  localparam int DEF_ENTRIES = 32;

  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FLOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  localparam logic [WIN_W-1:0]   WINDOW_RST    = 16'd60;
  localparam logic [VOL_W-1:0]   MIN_FLOW_RST  = 21'd0;
  localparam logic [RATIO_W-1:0] THRESHOLD_RST = 29'd768;

  localparam logic [VOL_W-1:0]   VOL_MAX   = 21'h1FFFFF;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 29'd256;

  typedef struct packed {
    logic [1:0]        operation;
    logic [3:0]        instrument;
    logic              side_no;
    logic [QTY_W-1:0]  quantity;
    logic [TIME_W-1:0] time_ms;
  } in_t;

  typedef struct packed {
    logic [VOL_W-1:0]   yes_vol;
    logic [VOL_W-1:0]   no_vol;
    logic [RATIO_W-1:0] ratio_q8;
    logic               imbalanced;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic ovf_rd;
    logic ovf_chk;
    logic wr;
    logic init;
    logic scan;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ring_full;
    logic do_write;
    logic scan_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== design/wfig_div.sv =====
// Restoring divider, one quotient bit per cycle, for the Q.8 ratio.
`default_nettype none
module wfig_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wfig_pkg::RATIO_W-1:0] num,
  input  logic [wfig_pkg::VOL_W-1:0]   den,
  output logic                         done,
  output logic [wfig_pkg::RATIO_W-1:0] quo
);
  import wfig_pkg::*;

  localparam int STEP_W = $clog2(RATIO_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [STEP_W-1:0]  step_r;
  logic [VOL_W-1:0]   rem_r;
  logic [VOL_W-1:0]   den_r;
  logic [RATIO_W-1:0] quo_r;
  logic [VOL_W:0]     rem_sh;
  logic [VOL_W:0]     rem_sub;
  logic               ge;

  assign rem_sh  = {rem_r, quo_r[RATIO_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(RATIO_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? VOL_W'(rem_sub) : VOL_W'(rem_sh);
      quo_r <= {quo_r[RATIO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ===== design/wfig_dp.sv =====
// Datapath: fill rings, head and count tables, window scan, ratio and flag, result register.
`default_nettype none
`include "windowed_flow_imbalance_guard_unit_defines.svh"
module wfig_dp #(
  parameter int KEYS    = wfig_pkg::DEF_KEYS,
  parameter int ENTRIES = wfig_pkg::DEF_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  wfig_pkg::in_t                   in_data,
  input  logic                            cfg_we,
  input  logic [wfig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wfig_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wfig_pkg::cmd_t                  cmd,
  output wfig_pkg::status_t               status,
  input  logic                            out_ready,
  output logic                            out_valid,
  output wfig_pkg::out_t                  out_data
);
  import wfig_pkg::*;

  localparam int KW     = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int EW     = $clog2(ENTRIES);
  localparam int CW     = $clog2(ENTRIES + 1);
  localparam int DEPTH  = KEYS * ENTRIES;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WMS_W  = WIN_W + MS_W;
  localparam int PROD_W = RATIO_W + VOL_W;
  localparam logic [CW-1:0] ENT_CNT  = CW'(ENTRIES);
  localparam logic [CW-1:0] ENT_LAST = CW'(ENTRIES - 1);

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic              side;
    logic [QTY_W-1:0]  qty;
  } entry_t;

  function automatic logic [EW-1:0] wrap_add(input logic [EW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(ENTRIES)) s = s - (CW+1)'(ENTRIES);
    return EW'(s);
  endfunction

  function automatic logic [VOL_W-1:0] sat_add(input logic [VOL_W-1:0] v,
                                               input logic [QTY_W-1:0] q);
    logic [VOL_W:0] s;
    s = (VOL_W+1)'(v) + (VOL_W+1)'(q);
    return (s > (VOL_W+1)'(VOL_MAX)) ? VOL_MAX : VOL_W'(s);
  endfunction

  logic [WIN_W-1:0]   win_r;
  logic [VOL_W-1:0]   minf_r;
  logic [RATIO_W-1:0] thr_r;

  logic [EW-1:0] head_arr_r [KEYS];
  logic [CW-1:0] cnt_arr_r  [KEYS];
  entry_t        mem_r      [DEPTH];
  entry_t        rd_data_r;

  in_t                item_r;
  logic [AW-1:0]      base_r;
  logic [EW-1:0]      head_r;
  logic [CW-1:0]      cnt_r;
  logic [TIME_W-1:0]  cut_r;
  logic               cut_en_r;
  logic               ovf_r;
  logic [CW-1:0]      scan_cnt_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      drops_r;
  logic               prefix_r;
  logic               dv_r;
  logic [VOL_W-1:0]   yes_r;
  logic [VOL_W-1:0]   no_r;
  logic [PROD_W-1:0]  prod_r;
  logic               flow_ok_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic [KW-1:0]      key_idx;
  logic               key_ok;
  logic [EW-1:0]      arr_head;
  logic [CW-1:0]      arr_cnt;
  logic               is_fill;
  logic [WMS_W-1:0]   wms;
  logic               old_rd;
  logic               rd_scan;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic [VOL_W-1:0]   hi;
  logic [VOL_W-1:0]   lo;
  logic [VOL_W-1:0]   den;
  logic [RATIO_W-1:0] num;
  logic               div_done;
  logic [RATIO_W-1:0] quo;
  out_t               result;

  assign key_idx  = KW'(item_r.instrument);
  assign key_ok   = {28'd0, item_r.instrument} < 32'(KEYS);
  assign arr_head = key_ok ? head_arr_r[key_idx] : '0;
  assign arr_cnt  = key_ok ? cnt_arr_r[key_idx] : '0;
  assign is_fill  = key_ok && (item_r.operation == OP_FILL);
  assign wms      = WMS_W'(win_r) * WMS_W'(MS_PER_S);
  assign old_rd   = cut_en_r && (rd_data_r.t < cut_r);
  assign rd_scan  = cmd.scan && (idx_r < scan_cnt_r);
  assign rd_en    = cmd.ovf_rd || rd_scan;
  assign rd_addr  = base_r + AW'(cmd.ovf_rd ? head_r : wrap_add(head_r, idx_r));
  assign wr_addr  = base_r + AW'(wrap_add(head_r, cnt_r));

  assign hi  = (yes_r > no_r) ? yes_r : no_r;
  assign lo  = (yes_r > no_r) ? no_r : yes_r;
  assign den = (lo == '0) ? VOL_W'(1) : lo;
  assign num = {hi, {FRAC_W{1'b0}}};

  wfig_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.commit),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    result = '0;
    if (item_r.operation != OP_NONE) begin
      result.yes_vol    = yes_r;
      result.no_vol     = no_r;
      result.ratio_q8   = (hi == '0) ? RATIO_ONE : quo;
      result.imbalanced = flow_ok_r && (PROD_W'(num) > prod_r);
      result.overflow   = ovf_r;
    end
  end

  assign status.ring_full = is_fill && (arr_cnt == ENT_CNT);
  assign status.do_write  = is_fill;
  assign status.scan_done = (idx_r == scan_cnt_r) && !dv_r;
  assign status.div_done  = div_done;
  assign status.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= WINDOW_RST;
      minf_r      <= MIN_FLOW_RST;
      thr_r       <= THRESHOLD_RST;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      for (int k = 0; k < KEYS; k++) begin
        head_arr_r[k] <= '0;
        cnt_arr_r[k]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW:    win_r  <= WIN_W'(cfg_data);
          REG_MIN_FLOW:  minf_r <= VOL_W'(cfg_data);
          REG_THRESHOLD: thr_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      dv_r <= rd_scan;
      if (cmd.commit && key_ok) begin
        unique case (item_r.operation)
          OP_FILL: begin
            head_arr_r[key_idx] <= wrap_add(head_r, drops_r);
            cnt_arr_r[key_idx]  <= cnt_r - drops_r;
          end
          OP_CLEAR: begin
            head_arr_r[key_idx] <= '0;
            cnt_arr_r[key_idx]  <= '0;
          end
          default: begin
          end
        endcase
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[wr_addr] <= '{t: item_r.time_ms, side: item_r.side_no, qty: item_r.quantity};
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.load) begin
      base_r   <= key_ok ? AW'(AW'(key_idx) * AW'(ENTRIES)) : '0;
      head_r   <= arr_head;
      cnt_r    <= arr_cnt;
      cut_en_r <= item_r.time_ms >= TIME_W'(wms);
      cut_r    <= item_r.time_ms - TIME_W'(wms);
      ovf_r    <= 1'b0;
    end
    if (cmd.ovf_chk) begin
      ovf_r  <= !old_rd;
      head_r <= wrap_add(head_r, CW'(1));
      cnt_r  <= ENT_LAST;
    end
    if (cmd.wr) begin
      cnt_r <= cnt_r + CW'(1);
    end
    if (cmd.init) begin
      idx_r      <= '0;
      drops_r    <= '0;
      prefix_r   <= 1'b1;
      yes_r      <= '0;
      no_r       <= '0;
      scan_cnt_r <= (key_ok && (item_r.operation inside {OP_FILL, OP_QUERY})) ? cnt_r : '0;
    end
    if (cmd.scan) begin
      if (rd_scan) begin
        idx_r <= idx_r + CW'(1);
      end
      if (dv_r) begin
        if (old_rd) begin
          if (prefix_r) begin
            drops_r <= drops_r + CW'(1);
          end
        end else begin
          prefix_r <= 1'b0;
          if (rd_data_r.side) begin
            no_r <= sat_add(no_r, rd_data_r.qty);
          end else begin
            yes_r <= sat_add(yes_r, rd_data_r.qty);
          end
        end
      end
    end
    if (cmd.commit) begin
      prod_r    <= PROD_W'(thr_r) * PROD_W'(den);
      flow_ok_r <= ((VOL_W+1)'(yes_r) + (VOL_W+1)'(no_r)) >= (VOL_W+1)'(minf_r);
    end
    if (cmd.emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `WFIG_ASSERT_IMP(a_scan_data_issued, dv_r, $past(cmd.scan))
  `WFIG_ASSERT_IMP(a_commit_drained, cmd.commit, !dv_r)
  `WFIG_ASSERT_IMP(a_emit_room, cmd.emit, status.out_free)
  `WFIG_ASSERT_NXT(a_emit_shows, cmd.emit, out_valid_r)

endmodule
`default_nettype wire

// ===== design/wfig_ctrl.sv =====
// Controller: sequences load, overflow check, append, scan, divide and result hand-off.
`default_nettype none
module wfig_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wfig_pkg::status_t status,
  output wfig_pkg::cmd_t    cmd
);
  import wfig_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_OVF_RD, S_OVF_CHK, S_WRITE, S_INIT, S_SCAN, S_COMMIT, S_DIV, S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (status.ring_full) begin
          state_nxt = S_OVF_RD;
        end else if (status.do_write) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_INIT;
        end
      end
      S_OVF_RD: begin
        cmd.ovf_rd = 1'b1;
        state_nxt  = S_OVF_CHK;
      end
      S_OVF_CHK: begin
        cmd.ovf_chk = 1'b1;
        state_nxt   = S_WRITE;
      end
      S_WRITE: begin
        cmd.wr    = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE) && !(state_r == S_IDLE && in_valid && in_ready_r);
    end
  end

  assign in_ready = in_ready_r;

endmodule
`default_nettype wire

// ===== design/windowed_flow_imbalance_guard_unit.sv =====
// Top level of the windowed flow imbalance guard.
// Requests arrive on in_valid/in_ready with in_data; one result per request
// leaves on out_valid/out_ready with out_data. A request is a fill, a query or
// a clear for one instrument; the result carries windowed yes/no volume, the
// Q.8 ratio, the imbalance flag and the ring overflow bit.
// Registers are written on the cfg port (cfg_we, cfg_index, cfg_data); the user
// must write them only while idle; the block itself does not enforce it.
// One request is in work at a time. The scan reads one stored fill per cycle
// from the ring memory, at most ENTRIES of them, then the ratio divider works
// out its 29 quotient bits one by one. in_ready rises together with out_valid,
// so a new request is taken only once the last result is in the output register.
// A finished result waits in the output register while the receiver stalls;
// the next request is taken meanwhile and holds before hand-off until it is free.
// Synchronous reset empties every ring at once and loads the register defaults.
`default_nettype none
module windowed_flow_imbalance_guard_unit #(
  parameter int KEYS    = wfig_pkg::DEF_KEYS,
  parameter int ENTRIES = wfig_pkg::DEF_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wfig_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wfig_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [wfig_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wfig_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wfig_pkg::*;

  cmd_t    cmd;
  status_t status;

  wfig_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wfig_dp #(
    .KEYS    (KEYS),
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
